// File: hw/rtl/mre_pkg.sv
package mre_pkg;

  localparam int unsigned NUM_COMP = 16;
  localparam int unsigned DIM = 4;
  localparam int unsigned K_W = (NUM_COMP > 1) ? $clog2(NUM_COMP) : 1;
  localparam int unsigned D_W = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int unsigned CA_W = (NUM_COMP * DIM > 1) ? $clog2(NUM_COMP * DIM) : 1;
  localparam int unsigned SA_W = (NUM_COMP * DIM * DIM > 1) ? $clog2(NUM_COMP * DIM * DIM) : 1;
  localparam int unsigned ACC_W = 49 + D_W;
  localparam int unsigned EXP_STEPS = 21;
  localparam int unsigned B_W = 5;
  localparam int unsigned NUM_W = 63;
  localparam int unsigned DEN_W = 31 + K_W;
  localparam int unsigned DIV_CNT_W = $clog2(NUM_W);

  localparam logic [1:0] MODE_CENTER = 2'd0;
  localparam logic [1:0] MODE_SHAPE  = 2'd1;
  localparam logic [1:0] MODE_LOGW   = 2'd2;
  localparam logic [1:0] MODE_POINT  = 2'd3;

  localparam logic [2:0] ADDR_MASK = 3'd0;
  localparam logic [2:0] ADDR_THR  = 3'd4;

  localparam logic [30:0] EXP_TAB [0:EXP_STEPS-1] = '{
    31'd1073725440, 31'd1073709056, 31'd1073676290, 31'd1073610760,
    31'd1073479712, 31'd1073217664, 31'd1072693760, 31'd1071646719,
    31'd1069547571, 31'd1065385900, 31'd1057095000, 31'd1040706261,
    31'd1008687096, 31'd947573834,  31'd836230973,  31'd651257337,
    31'd395007542,  31'd145315154,  31'd19666267,   31'd360200,
    31'd121
  };

  typedef struct packed {
    logic [1:0]         mode;
    logic [3:0]         component;
    logic [3:0]         row_index;
    logic [3:0]         col_index;
    logic signed [31:0] value;
    logic [31:0]        point_weight;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  result_component;
    logic [31:0] responsibility;
    logic        skipped;
    logic        last_result;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_CLEAR, OP_DY, OP_VMUL, OP_VACC, OP_QMUL, OP_QACC, OP_SCORE,
    OP_XINIT, OP_XSTEP, OP_XDONE, OP_DMUL, OP_DSTART, OP_LOAD
  } op_t;

  typedef struct packed {
    op_t            op;
    logic [K_W-1:0] k;
    logic [D_W-1:0] i;
    logic [D_W-1:0] j;
    logic [B_W-1:0] b;
    logic           first;
    logic           last;
    logic           skip;
  } cmd_t;

  typedef struct packed {
    logic g_below;
    logic div_valid;
  } stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [31:0] res;
    if ((&v[ACC_W-1:31]) || !(|v[ACC_W-1:31])) begin
      res = v[31:0];
    end else if (v[ACC_W-1]) begin
      res = 32'sh80000000;
    end else begin
      res = 32'sh7fffffff;
    end
    return res;
  endfunction

endpackage

// File: hw/rtl/mre_div.sv
module mre_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [mre_pkg::NUM_W-1:0]   num,
  input  logic [mre_pkg::DEN_W-1:0]   den,
  output logic                        valid,
  output logic [mre_pkg::NUM_W-1:0]   quo
);

  logic                             busy_r;
  logic                             valid_r;
  logic [mre_pkg::DIV_CNT_W-1:0]    cnt_r;
  logic [mre_pkg::DEN_W-1:0]        rem_r;
  logic [mre_pkg::NUM_W-1:0]        quo_r;
  logic [mre_pkg::DEN_W:0]          trial;
  logic                             fits;

  assign trial = {rem_r, quo_r[mre_pkg::NUM_W-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      valid_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      valid_r <= busy_r && (cnt_r == '0);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= mre_pkg::DIV_CNT_W'(mre_pkg::NUM_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
    end else if (busy_r) begin
      rem_r <= fits ? mre_pkg::DEN_W'(trial - {1'b0, den}) : mre_pkg::DEN_W'(trial);
      quo_r <= {quo_r[mre_pkg::NUM_W-2:0], fits};
    end
  end

  assign valid = valid_r;
  assign quo   = quo_r;

endmodule

// File: hw/rtl/mre_datapath.sv
module mre_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  mre_pkg::in_item_t   in_data,
  input  mre_pkg::cmd_t       cmd,
  input  logic [31:0]         skip_threshold,
  output mre_pkg::stat_t      stat,
  output mre_pkg::out_item_t  out_data
);

  logic [31:0] center_mem [mre_pkg::NUM_COMP*mre_pkg::DIM];
  logic [31:0] shape_mem  [mre_pkg::NUM_COMP*mre_pkg::DIM*mre_pkg::DIM];
  logic [31:0] logw_mem   [mre_pkg::NUM_COMP];
  logic [31:0] point_r    [mre_pkg::DIM];
  logic [31:0] dy_r       [mre_pkg::DIM];
  logic [31:0] score_r    [mre_pkg::NUM_COMP];

  logic [31:0] c_rd_r, s_rd_r, lw_rd_r, g_r;
  logic [63:0] prod_r;
  logic signed [mre_pkg::ACC_W-1:0] vacc_r, qacc_r, prod_sh;
  logic signed [31:0] best_r;
  logic found_r;
  logic [20:0] t_r;
  logic tbig_r;
  logic [30:0] r_r;
  logic [mre_pkg::DEN_W-1:0] sum_r;
  mre_pkg::out_item_t out_r;

  logic comp_ok, row_ok, col_ok;
  logic [mre_pkg::CA_W-1:0] c_waddr, c_raddr;
  logic [mre_pkg::SA_W-1:0] s_waddr, s_raddr;
  logic [mre_pkg::D_W-1:0] dy_sel;
  logic signed [31:0] dy_rd, dy_new, q_val, s_val;
  logic signed [32:0] pdiff, sdiff, tdiff;
  logic [61:0] xprod, xround;
  logic [30:0] e_val;
  logic div_valid;
  logic [mre_pkg::NUM_W-1:0] div_num, div_quo;

  assign comp_ok = 32'(in_data.component) < mre_pkg::NUM_COMP;
  assign row_ok  = 32'(in_data.row_index) < mre_pkg::DIM;
  assign col_ok  = 32'(in_data.col_index) < mre_pkg::DIM;

  assign c_waddr = mre_pkg::CA_W'(32'(in_data.component) * mre_pkg::DIM
                   + 32'(in_data.row_index));
  assign s_waddr = mre_pkg::SA_W'((32'(in_data.component) * mre_pkg::DIM
                   + 32'(in_data.row_index)) * mre_pkg::DIM + 32'(in_data.col_index));
  assign c_raddr = mre_pkg::CA_W'(32'(cmd.k) * mre_pkg::DIM + 32'(cmd.j));
  assign s_raddr = mre_pkg::SA_W'((32'(cmd.k) * mre_pkg::DIM + 32'(cmd.i)) * mre_pkg::DIM
                   + 32'(cmd.j));

  always_ff @(posedge clk) begin
    if (in_fire && comp_ok) begin
      if (in_data.mode == mre_pkg::MODE_CENTER && row_ok) begin
        center_mem[c_waddr] <= in_data.value;
      end
      if (in_data.mode == mre_pkg::MODE_SHAPE && row_ok && col_ok) begin
        shape_mem[s_waddr] <= in_data.value;
      end
      if (in_data.mode == mre_pkg::MODE_LOGW) begin
        logw_mem[mre_pkg::K_W'(in_data.component)] <= in_data.value;
      end
    end
    c_rd_r  <= center_mem[c_raddr];
    s_rd_r  <= shape_mem[s_raddr];
    lw_rd_r <= logw_mem[cmd.k];
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_data.mode == mre_pkg::MODE_POINT) begin
      if (row_ok) begin
        point_r[in_data.row_index[mre_pkg::D_W-1:0]] <= in_data.value;
      end
      if (in_data.last) begin
        g_r <= in_data.point_weight;
      end
    end
  end

  assign dy_sel  = (cmd.op == mre_pkg::OP_QMUL) ? cmd.i : cmd.j;
  assign dy_rd   = dy_r[dy_sel];
  assign pdiff   = $signed({point_r[cmd.j][31], point_r[cmd.j]}) - $signed({c_rd_r[31], c_rd_r});
  assign dy_new  = mre_pkg::sat32(mre_pkg::ACC_W'(pdiff));
  assign prod_sh = mre_pkg::ACC_W'($signed(prod_r) >>> 16);
  assign q_val   = mre_pkg::sat32(qacc_r >>> 1);
  assign sdiff   = $signed({lw_rd_r[31], lw_rd_r}) - $signed({q_val[31], q_val});
  assign s_val   = mre_pkg::sat32(mre_pkg::ACC_W'(sdiff));
  assign tdiff   = $signed({best_r[31], best_r})
                   - $signed({score_r[cmd.k][31], score_r[cmd.k]});
  assign xprod   = 62'(r_r) * 62'(mre_pkg::EXP_TAB[cmd.b]);
  assign xround  = xprod + (62'd1 << 29);
  assign e_val   = tbig_r ? 31'd0 : r_r;
  assign div_num = prod_r[mre_pkg::NUM_W-1:0] + mre_pkg::NUM_W'(sum_r >> 1);

  always_ff @(posedge clk) begin
    case (cmd.op)
      mre_pkg::OP_CLEAR: begin
        found_r <= 1'b0;
        sum_r   <= '0;
      end
      mre_pkg::OP_DY: dy_r[cmd.j] <= dy_new;
      mre_pkg::OP_VMUL: prod_r <= 64'($signed(s_rd_r)) * 64'(dy_rd);
      mre_pkg::OP_VACC: vacc_r <= (cmd.first ? '0 : vacc_r) + prod_sh;
      mre_pkg::OP_QMUL: prod_r <= 64'(dy_rd) * 64'(mre_pkg::sat32(vacc_r));
      mre_pkg::OP_QACC: qacc_r <= (cmd.first ? '0 : qacc_r) + prod_sh;
      mre_pkg::OP_SCORE: begin
        score_r[cmd.k] <= s_val;
        if (!found_r || s_val > best_r) begin
          best_r <= s_val;
        end
        found_r <= 1'b1;
      end
      mre_pkg::OP_XINIT: begin
        t_r    <= tdiff[20:0];
        tbig_r <= |tdiff[32:21];
        r_r    <= 31'h40000000;
      end
      mre_pkg::OP_XSTEP: begin
        if (t_r[cmd.b]) begin
          r_r <= xround[60:30];
        end
      end
      mre_pkg::OP_XDONE: begin
        score_r[cmd.k] <= 32'(e_val);
        sum_r          <= sum_r + mre_pkg::DEN_W'(e_val);
      end
      mre_pkg::OP_DMUL: prod_r <= 64'(score_r[cmd.k]) * 64'(g_r);
      mre_pkg::OP_LOAD: begin
        out_r.result_component <= cmd.skip ? 4'd0 : 4'(cmd.k);
        out_r.responsibility   <= cmd.skip ? 32'd0 : div_quo[31:0];
        out_r.skipped          <= cmd.skip;
        out_r.last_result      <= cmd.skip | cmd.last;
      end
      default: ;
    endcase
  end

  mre_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.op == mre_pkg::OP_DSTART),
    .num   (div_num),
    .den   (sum_r),
    .valid (div_valid),
    .quo   (div_quo)
  );

  assign stat.g_below   = g_r < skip_threshold;
  assign stat.div_valid = div_valid;
  assign out_data       = out_r;

endmodule

// File: hw/rtl/mre_ctrl.sv
module mre_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [mre_pkg::NUM_COMP-1:0]  mask,
  input  mre_pkg::stat_t                stat,
  input  logic                          out_stall,
  output mre_pkg::cmd_t                 cmd,
  output logic                          idle,
  output logic                          out_valid
);

  typedef enum logic [19:0] {
    S_IDLE    = 20'h00001,
    S_CHECK   = 20'h00002,
    S_K_SCAN  = 20'h00004,
    S_DY_RD   = 20'h00008,
    S_DY_WR   = 20'h00010,
    S_V_RD    = 20'h00020,
    S_V_MUL   = 20'h00040,
    S_V_ACC   = 20'h00080,
    S_Q_MUL   = 20'h00100,
    S_Q_ACC   = 20'h00200,
    S_SCORE   = 20'h00400,
    S_X_SCAN  = 20'h00800,
    S_X_INIT  = 20'h01000,
    S_X_STEP  = 20'h02000,
    S_X_DONE  = 20'h04000,
    S_D_SCAN  = 20'h08000,
    S_D_MUL   = 20'h10000,
    S_D_START = 20'h20000,
    S_D_WAIT  = 20'h40000,
    S_EMIT    = 20'h80000
  } state_t;

  state_t state_r, state_nxt;
  logic [mre_pkg::K_W-1:0] k_r, k_nxt;
  logic [mre_pkg::D_W-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [mre_pkg::B_W-1:0] b_r, b_nxt;
  logic skip_r, skip_nxt;
  logic k_last, j_last, i_last, none_above, skip_now;

  assign k_last = k_r == mre_pkg::K_W'(mre_pkg::NUM_COMP - 1);
  assign j_last = j_r == mre_pkg::D_W'(mre_pkg::DIM - 1);
  assign i_last = i_r == mre_pkg::D_W'(mre_pkg::DIM - 1);
  assign skip_now = stat.g_below || (mask == '0);

  always_comb begin
    none_above = 1'b1;
    for (int n = 0; n < mre_pkg::NUM_COMP; n++) begin
      if (n > int'(k_r) && mask[n]) begin
        none_above = 1'b0;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    b_nxt     = b_r;
    skip_nxt  = skip_r;
    cmd.op    = mre_pkg::OP_NONE;
    cmd.k     = k_r;
    cmd.i     = i_r;
    cmd.j     = j_r;
    cmd.b     = b_r;
    cmd.first = 1'b0;
    cmd.last  = none_above;
    cmd.skip  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        k_nxt    = '0;
        skip_nxt = skip_now;
        if (skip_now) begin
          cmd.op    = mre_pkg::OP_LOAD;
          cmd.skip  = 1'b1;
          state_nxt = S_EMIT;
        end else begin
          cmd.op    = mre_pkg::OP_CLEAR;
          state_nxt = S_K_SCAN;
        end
      end
      S_K_SCAN: begin
        if (mask[k_r]) begin
          j_nxt     = '0;
          state_nxt = S_DY_RD;
        end else if (k_last) begin
          k_nxt     = '0;
          state_nxt = S_X_SCAN;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_DY_RD: state_nxt = S_DY_WR;
      S_DY_WR: begin
        cmd.op = mre_pkg::OP_DY;
        if (j_last) begin
          i_nxt     = '0;
          j_nxt     = '0;
          state_nxt = S_V_RD;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_DY_RD;
        end
      end
      S_V_RD: state_nxt = S_V_MUL;
      S_V_MUL: begin
        cmd.op    = mre_pkg::OP_VMUL;
        state_nxt = S_V_ACC;
      end
      S_V_ACC: begin
        cmd.op    = mre_pkg::OP_VACC;
        cmd.first = j_r == '0;
        if (j_last) begin
          j_nxt     = '0;
          state_nxt = S_Q_MUL;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_V_RD;
        end
      end
      S_Q_MUL: begin
        cmd.op    = mre_pkg::OP_QMUL;
        state_nxt = S_Q_ACC;
      end
      S_Q_ACC: begin
        cmd.op    = mre_pkg::OP_QACC;
        cmd.first = i_r == '0;
        if (i_last) begin
          state_nxt = S_SCORE;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_V_RD;
        end
      end
      S_SCORE: begin
        cmd.op = mre_pkg::OP_SCORE;
        if (k_last) begin
          k_nxt     = '0;
          state_nxt = S_X_SCAN;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_K_SCAN;
        end
      end
      S_X_SCAN: begin
        if (mask[k_r]) begin
          state_nxt = S_X_INIT;
        end else if (k_last) begin
          k_nxt     = '0;
          state_nxt = S_D_SCAN;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_X_INIT: begin
        cmd.op    = mre_pkg::OP_XINIT;
        b_nxt     = '0;
        state_nxt = S_X_STEP;
      end
      S_X_STEP: begin
        cmd.op = mre_pkg::OP_XSTEP;
        if (b_r == mre_pkg::B_W'(mre_pkg::EXP_STEPS - 1)) begin
          state_nxt = S_X_DONE;
        end else begin
          b_nxt = b_r + 1'b1;
        end
      end
      S_X_DONE: begin
        cmd.op = mre_pkg::OP_XDONE;
        if (k_last) begin
          k_nxt     = '0;
          state_nxt = S_D_SCAN;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_X_SCAN;
        end
      end
      S_D_SCAN: begin
        if (mask[k_r]) begin
          state_nxt = S_D_MUL;
        end else if (k_last) begin
          state_nxt = S_IDLE;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_D_MUL: begin
        cmd.op    = mre_pkg::OP_DMUL;
        state_nxt = S_D_START;
      end
      S_D_START: begin
        cmd.op    = mre_pkg::OP_DSTART;
        state_nxt = S_D_WAIT;
      end
      S_D_WAIT: begin
        if (stat.div_valid) begin
          cmd.op    = mre_pkg::OP_LOAD;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_stall) begin
          if (skip_r || none_above) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = S_D_SCAN;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
      i_r     <= '0;
      j_r     <= '0;
      b_r     <= '0;
      skip_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      b_r     <= b_nxt;
      skip_r  <= skip_nxt;
    end
  end

  assign idle      = state_r == S_IDLE;
  assign out_valid = state_r == S_EMIT;

endmodule

// File: hw/rtl/mixture_responsibility_engine_top.sv
// mixture responsibility engine: gaussian mixture e-step responsibilities
// input channel (in_valid/in_stall/in_data): load requests fill the center,
// shape matrix and log weight stores, one element each; point requests stream
// the point one element per request, the one marked last carries the weight g
// and starts the evaluation.
// while a point is evaluated in_stall stays high; loads and non-last point
// elements do not raise in_stall.
// a point gives one result per active component in ascending order, or one
// skipped result; the skipped result is loaded in S_CHECK and valid in S_EMIT.
// per active component the score is formed on the shared product register, each
// exp runs one table step per cycle and each result goes through the bit-serial
// divider; an inactive component is passed over in each scan pass. after the
// last result is taken the engine returns to idle and takes the next request.
// out_valid holds each result until the receiver drops out_stall; the engine
// waits meanwhile and keeps in_stall high.
// configuration (apb, byte addresses 0 active mask, 4 skip threshold) is to be
// written while the engine is idle; the block does not enforce it. reset sets
// mask to component 0, threshold to zero; stores are undefined until loaded.
module mixture_responsibility_engine_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mre_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mre_pkg::out_item_t  out_data,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [2:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);

  logic [15:0] mask_r;
  logic [31:0] thr_r;
  logic cfg_wr, in_fire, start, idle;
  mre_pkg::cmd_t cmd;
  mre_pkg::stat_t stat;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= 16'd1;
      thr_r  <= 32'd0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr)
        mre_pkg::ADDR_MASK: mask_r <= cfg_pwdata[15:0];
        mre_pkg::ADDR_THR:  thr_r  <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr)
      mre_pkg::ADDR_MASK: cfg_prdata = {16'd0, mask_r};
      mre_pkg::ADDR_THR:  cfg_prdata = thr_r;
      default:            cfg_prdata = 32'd0;
    endcase
  end

  assign in_stall = !idle;
  assign in_fire  = in_valid && !in_stall;
  assign start    = in_fire && (in_data.mode == mre_pkg::MODE_POINT) && in_data.last;

  mre_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .mask      (mask_r[mre_pkg::NUM_COMP-1:0]),
    .stat      (stat),
    .out_stall (out_stall),
    .cmd       (cmd),
    .idle      (idle),
    .out_valid (out_valid)
  );

  mre_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_fire        (in_fire),
    .in_data        (in_data),
    .cmd            (cmd),
    .skip_threshold (thr_r),
    .stat           (stat),
    .out_data       (out_data)
  );

endmodule

// File: dv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 5000000;
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned HOLD_OFF_CYCLES = 3000;
  localparam int unsigned RANDOM_REQUESTS = 330;

  class resp_scoreboard;
    longint center_mem[64];
    longint shape_mem[256];
    longint logw_mem[16];
    longint point_mem[4];
    logic [15:0] mask;
    logic [31:0] threshold;
    mre_pkg::out_item_t awaited[$];
    int mismatches;
    longint unsigned decay_tab[21];

    function new();
      mask = 16'h0001;
      threshold = '0;
      mismatches = 0;
      decay_tab = '{
        1073725440, 1073709056, 1073676290, 1073610760, 1073479712, 1073217664,
        1072693760, 1071646719, 1069547571, 1065385900, 1057095000, 1040706261,
        1008687096, 947573834, 836230973, 651257337, 395007542, 145315154,
        19666267, 360200, 121
      };
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint comp_score(int k);
      longint dy[4];
      longint v;
      longint acc;
      acc = 0;
      for (int i = 0; i < 4; i++) dy[i] = clamp32(point_mem[i] - center_mem[k*4+i]);
      for (int i = 0; i < 4; i++) begin
        v = 0;
        for (int j = 0; j < 4; j++) v += (shape_mem[(k*4+i)*4+j] * dy[j]) >>> 16;
        v = clamp32(v);
        acc += (dy[i] * v) >>> 16;
      end
      acc = clamp32(acc >>> 1);
      return clamp32(logw_mem[k] - acc);
    endfunction

    function longint unsigned decay(longint unsigned t);
      longint unsigned r;
      r = 64'd1 << 30;
      if (t >= (64'd32 << 16)) return 0;
      for (int b = 0; b < 21; b++)
        if (t[b]) r = (r * decay_tab[b] + (64'd1 << 29)) >> 30;
      return r;
    endfunction

    function void evaluate_point(logic [31:0] g);
      longint s[16];
      longint best;
      longint unsigned e[16];
      longint unsigned sum;
      longint unsigned q;
      int total;
      int n;
      bit found;
      mre_pkg::out_item_t r;
      found = 0;
      total = 0;
      n = 0;
      sum = 0;
      best = 0;
      if (g < threshold || mask == 16'h0000) begin
        r = '0;
        r.skipped = 1'b1;
        r.last_result = 1'b1;
        awaited.push_back(r);
        return;
      end
      for (int k = 0; k < 16; k++) begin
        if (!mask[k]) continue;
        s[k] = comp_score(k);
        if (!found || s[k] > best) best = s[k];
        found = 1;
        total++;
      end
      for (int k = 0; k < 16; k++) begin
        if (!mask[k]) continue;
        e[k] = decay(longint'(best - s[k]));
        sum += e[k];
      end
      for (int k = 0; k < 16; k++) begin
        if (!mask[k]) continue;
        q = (e[k] * longint'(g) + sum / 2) / sum;
        r.result_component = k[3:0];
        r.responsibility = q[31:0];
        r.skipped = 1'b0;
        r.last_result = (n + 1 == total);
        awaited.push_back(r);
        n++;
      end
    endfunction

    function void note_request(mre_pkg::in_item_t it);
      longint val;
      val = longint'(it.value);
      case (it.mode)
        mre_pkg::MODE_CENTER: begin
          if (it.row_index < mre_pkg::DIM) center_mem[it.component*4+it.row_index] = val;
        end
        mre_pkg::MODE_SHAPE: begin
          if (it.row_index < mre_pkg::DIM && it.col_index < mre_pkg::DIM)
            shape_mem[(it.component*4+it.row_index)*4+it.col_index] = val;
        end
        mre_pkg::MODE_LOGW: logw_mem[it.component] = val;
        default: begin
          if (it.row_index < mre_pkg::DIM) point_mem[it.row_index] = val;
          if (it.last) evaluate_point(it.point_weight);
        end
      endcase
    endfunction

    function void check_result(mre_pkg::out_item_t got);
      mre_pkg::out_item_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: comp %0d resp %0d skip %0b last %0b",
                   got.result_component, got.responsibility, got.skipped, got.last_result);
        return;
      end
      want = awaited.pop_front();
      if (got.result_component !== want.result_component ||
          got.responsibility !== want.responsibility ||
          got.skipped !== want.skipped || got.last_result !== want.last_result) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: exp comp %0d resp %0d skip %0b last %0b, ",
                    "got comp %0d resp %0d skip %0b last %0b"},
                   want.result_component, want.responsibility, want.skipped,
                   want.last_result, got.result_component, got.responsibility,
                   got.skipped, got.last_result);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  mre_pkg::in_item_t in_data;
  logic out_valid;
  logic out_stall;
  mre_pkg::out_item_t out_data;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [2:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  resp_scoreboard sb;
  int unsigned cycles = 0;
  int burst_left = 0;
  int sent = 0;
  bit hold_req = 0;

  always #2 clk = ~clk;

  mixture_responsibility_engine_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid && !out_stall) sb.check_result(out_data);
  end

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int style;
    int style_left;
    int hold_left;
    out_stall = 1'b0;
    style = 0;
    style_left = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_OFF_CYCLES;
        hold_req = 0;
      end
      if (style_left == 0) begin
        style = int'($urandom_range(0, 3));
        style_left = int'($urandom_range(50, 400));
      end else begin
        style_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (style)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 1) == 1);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  function automatic mre_pkg::in_item_t make_req(logic [1:0] mode, logic [3:0] comp,
                                                 logic [3:0] row, logic [3:0] col,
                                                 logic [31:0] val, logic [31:0] g,
                                                 logic lst);
    mre_pkg::in_item_t it;
    it.mode = mode;
    it.component = comp;
    it.row_index = row;
    it.col_index = col;
    it.value = val;
    it.point_weight = g;
    it.last = lst;
    return it;
  endfunction

  function automatic logic [31:0] small_val();
    return $urandom_range(0, 262143) - 32'd131072;
  endfunction

  function automatic logic [31:0] shape_val();
    return $urandom_range(0, 32767) - 32'd16384;
  endfunction

  function automatic logic [31:0] rand_weight();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'h8000_0000;
      2: return 32'h4000_0000;
      default: return $urandom_range(0, 32'h8000_0000);
    endcase
  endfunction

  task automatic send_request(mre_pkg::in_item_t it);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    sb.note_request(it);
    sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = int'($urandom_range(0, 15));
      gap = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 6));
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic send_point(logic [31:0] g, bit broken);
    int bad_row;
    logic [3:0] row;
    bad_row = broken ? int'($urandom_range(0, 3)) : -1;
    for (int r = 0; r < 4; r++) begin
      row = (r == bad_row) ? 4'($urandom_range(4, 15)) : 4'(r);
      send_request(make_req(mre_pkg::MODE_POINT, 4'($urandom), row, 4'($urandom),
                            ($urandom_range(0, 15) == 0) ? $urandom : small_val(),
                            (r == 3) ? g : $urandom, r == 3));
    end
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (addr == mre_pkg::ADDR_MASK) sb.mask = data[15:0];
    else sb.threshold = data;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic reconfigure(logic [15:0] mask, logic [31:0] thr);
    settle();
    write_reg(mre_pkg::ADDR_MASK, {16'h0, mask});
    write_reg(mre_pkg::ADDR_THR, thr);
  endtask

  initial begin
    int pick;
    int next_cfg;
    logic [15:0] m;
    logic [31:0] t;
    bit pressed;
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // fill every store entry so that no point reads an unwritten one
    for (int k = 0; k < 16; k++) begin
      send_request(make_req(mre_pkg::MODE_LOGW, 4'(k), 4'($urandom), 4'($urandom),
                            small_val(), $urandom, 1'($urandom)));
      for (int i = 0; i < 4; i++) begin
        send_request(make_req(mre_pkg::MODE_CENTER, 4'(k), 4'(i), 4'($urandom),
                              small_val(), $urandom, 1'($urandom)));
        for (int j = 0; j < 4; j++)
          send_request(make_req(mre_pkg::MODE_SHAPE, 4'(k), 4'(i), 4'(j), shape_val(),
                                $urandom, 1'($urandom)));
      end
    end

    reconfigure(16'hFFFF, 32'h0);
    send_point(32'h8000_0000, 0);
    send_point(32'h0, 0);
    reconfigure(16'hFFFF, 32'h4000_0000);
    send_point(32'h4000_0000, 0);
    send_point(32'h3FFF_FFFF, 0);
    reconfigure(16'hFFFF, 32'h8000_0000);
    send_point(32'h8000_0000, 0);
    reconfigure(16'h0000, 32'h0);
    send_point(32'h8000_0000, 0);
    reconfigure(16'h8001, 32'h0);
    // ignored loads, a logw load, last flags; out-of-range row closing a point
    send_request(make_req(mre_pkg::MODE_SHAPE, 4'd0, 4'd1, 4'd15, 32'h7FFF_FFFF,
                          32'd0, 1'b1));
    send_request(make_req(mre_pkg::MODE_CENTER, 4'd15, 4'd9, 4'd0, 32'h8000_0000,
                          32'd0, 1'b1));
    send_request(make_req(mre_pkg::MODE_LOGW, 4'd15, 4'd15, 4'd15, small_val(),
                          32'd0, 1'b1));
    send_request(make_req(mre_pkg::MODE_POINT, 4'd7, 4'd12, 4'd3, 32'h7FFF_FFFF,
                          32'h2000_0000, 1'b1));
    // saturating values
    send_request(make_req(mre_pkg::MODE_CENTER, 4'd0, 4'd0, 4'd0, 32'h8000_0000,
                          32'd0, 1'b0));
    send_request(make_req(mre_pkg::MODE_SHAPE, 4'd0, 4'd0, 4'd0, 32'h7FFF_FFFF,
                          32'd0, 1'b0));
    send_request(make_req(mre_pkg::MODE_LOGW, 4'd0, 4'd0, 4'd0, 32'h8000_0000,
                          32'd0, 1'b0));
    send_request(make_req(mre_pkg::MODE_POINT, 4'd0, 4'd0, 4'd0, 32'h7FFF_FFFF,
                          32'd0, 1'b0));
    send_request(make_req(mre_pkg::MODE_POINT, 4'd0, 4'd2, 4'd0, small_val(),
                          32'h8000_0000, 1'b1));
    send_request(make_req(mre_pkg::MODE_CENTER, 4'd0, 4'd0, 4'd0, small_val(),
                          32'd0, 1'b0));
    send_request(make_req(mre_pkg::MODE_SHAPE, 4'd0, 4'd0, 4'd0, shape_val(),
                          32'd0, 1'b0));
    send_request(make_req(mre_pkg::MODE_LOGW, 4'd0, 4'd0, 4'd0, 32'h7FFF_FFFF,
                          32'd0, 1'b0));
    send_point(32'h8000_0000, 0);

    reconfigure(16'hFFFF, 32'h0);
    sent = 0;
    next_cfg = 80;
    pressed = 0;
    while (sent < RANDOM_REQUESTS) begin
      if (sent >= next_cfg) begin
        next_cfg += 80;
        case ($urandom_range(0, 4))
          0: m = 16'hFFFF;
          1: m = 16'h0000;
          2: m = 16'h1 << $urandom_range(0, 15);
          default: m = 16'($urandom);
        endcase
        case ($urandom_range(0, 5))
          0: t = 32'h8000_0000;
          1: t = $urandom_range(0, 32'h8000_0000);
          default: t = 32'h0;
        endcase
        reconfigure(m, t);
      end
      if (!pressed && sent >= 150) begin
        pressed = 1;
        hold_req = 1;
      end
      pick = int'($urandom_range(0, 99));
      if (pick < 65) begin
        send_point(rand_weight(), $urandom_range(0, 9) == 0);
      end else if (pick < 80) begin
        case ($urandom_range(0, 2))
          0: send_request(make_req(mre_pkg::MODE_CENTER, 4'($urandom),
                                   4'($urandom_range(0, 3)), 4'($urandom),
                                   small_val(), $urandom, 1'($urandom)));
          1: send_request(make_req(mre_pkg::MODE_SHAPE, 4'($urandom),
                                   4'($urandom_range(0, 3)), 4'($urandom_range(0, 3)),
                                   shape_val(), $urandom, 1'($urandom)));
          default: send_request(make_req(mre_pkg::MODE_LOGW, 4'($urandom), 4'($urandom),
                                         4'($urandom), small_val(), $urandom,
                                         1'($urandom)));
        endcase
      end else if (pick < 90) begin
        send_request(make_req(2'($urandom_range(0, 2)), 4'($urandom), 4'($urandom),
                              4'($urandom), $urandom, $urandom, 1'($urandom)));
      end else begin
        send_request(make_req(mre_pkg::MODE_POINT, 4'($urandom), 4'($urandom),
                              4'($urandom), small_val(), $urandom, 1'b0));
      end
    end

    settle();
    sb.mismatches += sb.awaited.size();
    if (sb.mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/mre_pkg.sv
hw/rtl/mre_div.sv
hw/rtl/mre_datapath.sv
hw/rtl/mre_ctrl.sv
hw/rtl/mixture_responsibility_engine_top.sv
dv/tb_top.sv
